/* sv/polynomial_coefficient_engine_defines.svh */
// Assertion macros shared by the polynomial coefficient engine RTL.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef POLYNOMIAL_COEFFICIENT_ENGINE_DEFINES_SVH
`define POLYNOMIAL_COEFFICIENT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pce: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pce: next-cycle check failed");

`endif

/* sv/pce_pkg.sv */
// Shared types and constants of the polynomial coefficient engine.
// No dependencies; every other file but the defines header imports this package.
`timescale 1ns / 1ps

package pce_pkg;

	localparam int MAX_TERMS     = 8;
	localparam int FRACTION_BITS = 16;
	localparam int DATA_W        = 32;
	localparam int ACTION_W      = 3;
	localparam int SLOT_W        = 3;
	localparam int TERM_W        = 4;
	localparam int THRESH_W      = 31;
	localparam int CFG_IDX_W     = 2;
	localparam int IDX_W         = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W         = $clog2(MAX_TERMS + 1);

	localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRACTION_BITS;

	typedef logic signed [DATA_W-1:0] fx_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD  = 3'd0,
		ACT_READ  = 3'd1,
		ACT_EVAL  = 3'd2,
		ACT_SHIFT = 3'd3,
		ACT_SCALE = 3'd4
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TERM_COUNT      = 2'd0,
		CFG_SHIFT_THRESHOLD = 2'd1
	} cfg_reg_t;

	// Request to the shared multiply-add unit: sat(floor(a*b >> F)) + c, saturated
	typedef struct packed {
		logic valid;
		fx_t  a;
		fx_t  b;
		fx_t  c;
	} mac_req_t;

	typedef struct packed {
		logic valid;
		fx_t  value;
		logic sat;
	} mac_rsp_t;

endpackage

/* sv/pce_item_if.sv */
// Input item channel of the polynomial coefficient engine.
// Depends on pce_pkg for field widths.
`timescale 1ns / 1ps

interface pce_item_if;
	import pce_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [SLOT_W-1:0]   slot;
	logic signed [DATA_W-1:0] coeff_in;
	logic signed [DATA_W-1:0] point;

	modport source (output valid, action, slot, coeff_in, point, input ready);
	modport sink (input valid, action, slot, coeff_in, point, output ready);
endinterface

/* sv/pce_result_if.sv */
// Result item channel of the polynomial coefficient engine.
// Depends on pce_pkg for field widths.
`timescale 1ns / 1ps

interface pce_result_if;
	import pce_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic                     saturated;

	modport source (output valid, result_value, saturated, input ready);
	modport sink (input valid, result_value, saturated, output ready);
endinterface

/* sv/pce_cfg_if.sv */
// Configuration write channel of the polynomial coefficient engine.
// Depends on pce_pkg for index and data widths.
`timescale 1ns / 1ps

interface pce_cfg_if;
	import pce_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/polynomial_coefficient_engine.sv */
// Top level of the polynomial coefficient engine: coefficient store and sequencer.
// Depends on pce_pkg, the three channel interfaces, pce_mac and the defines header.
//
//   channel  role   carries
//   item     sink   action, slot, coeff_in, point
//   result   source result_value, saturated (one per item)
//   cfg      sink   index, data (term_count, shift_threshold); always ready
//
// Every product goes through one two-stage multiply-add unit; each step is an
// issue followed by a wait for the unit's response, preceded by a fetch when an
// operand must be read from the store first. One item is in work at a time.
// Reset clears the store and registers at once; no clearing pass.
// A finished result waits in the output register while the next item is taken;
// that next item holds in its last cycle until the output register is free.
`timescale 1ns / 1ps
`include "polynomial_coefficient_engine_defines.svh"

module polynomial_coefficient_engine (
	input  logic         clk,
	input  logic         arst_n,
	pce_item_if.sink     item,
	pce_result_if.source result,
	pce_cfg_if.sink      cfg
);
	import pce_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_ISSUE,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t              state_q;
	action_t             act_q;
	fx_t                 coeff_q [MAX_TERMS];
	logic [TERM_W-1:0]   term_count_q;
	logic [THRESH_W-1:0] thresh_q;
	fx_t                 x_q;
	fx_t                 acc_q;
	fx_t                 opa_q;
	logic                flag_q;
	logic                phase_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    k_q;
	logic [CNT_W-1:0]    n_q;
	logic                out_valid_q;
	fx_t                 out_value_q;
	logic                out_sat_q;

	logic [CNT_W-1:0]    n_act;
	logic [CNT_W-1:0]    idx_p1;
	logic [IDX_W-1:0]    rd_addr;
	fx_t                 rd_data;
	logic                slot_ok;
	logic [DATA_W-1:0]   x_mag;
	logic                shift_go;
	logic                more_k;
	mac_req_t            mac_req;
	mac_rsp_t            mac_rsp;

	// Clamp the configured term count to the store depth
	assign n_act = (32'(term_count_q) > 32'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
		: CNT_W'(term_count_q);
	assign idx_p1   = idx_q + CNT_W'(1);
	assign slot_ok  = 32'(item.slot) < 32'(MAX_TERMS);
	assign x_mag    = item.point[DATA_W-1] ? (~item.point + DATA_W'(1)) : item.point;
	assign shift_go = (x_mag > {1'b0, thresh_q}) && (n_act > CNT_W'(1));
	assign more_k   = ({1'b0, k_q} + (CNT_W + 1)'(2)) < {1'b0, n_q};

	// Single read port on the store
	always_comb begin
		case (state_q)
			ST_IDLE:  rd_addr = IDX_W'(item.slot);
			ST_FETCH: rd_addr = (act_q == ACT_SHIFT) ? idx_p1[IDX_W-1:0] : idx_q[IDX_W-1:0];
			default:  rd_addr = idx_q[IDX_W-1:0];
		endcase
	end
	assign rd_data = coeff_q[rd_addr];

	// Pick operands for the shared unit
	always_comb begin
		mac_req.valid = state_q == ST_ISSUE;
		mac_req.a     = '0;
		mac_req.b     = '0;
		mac_req.c     = '0;
		case (act_q)
			ACT_EVAL: begin
				mac_req.a = acc_q;
				mac_req.b = x_q;
				mac_req.c = rd_data;
			end
			ACT_SHIFT: begin
				mac_req.a = opa_q;
				mac_req.b = x_q;
				mac_req.c = rd_data;
			end
			ACT_SCALE: begin
				mac_req.a = phase_q ? acc_q : rd_data;
				mac_req.b = phase_q ? x_q : acc_q;
			end
			default: begin
				mac_req.a = '0;
			end
		endcase
	end

	pce_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	// Sequencer, store, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= ACT_LOAD;
			coeff_q      <= '{default: '0};
			term_count_q <= '0;
			thresh_q     <= THRESH_W'(1);
			x_q          <= '0;
			acc_q        <= '0;
			opa_q        <= '0;
			flag_q       <= 1'b0;
			phase_q      <= 1'b0;
			idx_q        <= '0;
			k_q          <= '0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_sat_q    <= 1'b0;
		end else begin
			// Take configuration writes; indexes past the list are dropped
			if (cfg.valid) begin
				if (cfg.index == CFG_TERM_COUNT) begin
					term_count_q <= cfg.data[TERM_W-1:0];
				end else if (cfg.index == CFG_SHIFT_THRESHOLD) begin
					thresh_q <= cfg.data[THRESH_W-1:0];
				end
			end

			// Load a finished result when the register is free, drop one once taken
			if (state_q == ST_DONE && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						act_q   <= action_t'(item.action);
						x_q     <= item.point;
						flag_q  <= 1'b0;
						phase_q <= 1'b0;
						k_q     <= '0;
						n_q     <= n_act;
						case (item.action)
							ACT_LOAD: begin
								acc_q   <= '0;
								state_q <= ST_DONE;
								if (slot_ok) begin
									coeff_q[rd_addr] <= item.coeff_in;
								end
							end
							ACT_READ: begin
								acc_q   <= slot_ok ? rd_data : '0;
								state_q <= ST_DONE;
							end
							ACT_EVAL: begin
								acc_q <= '0;
								if (n_act != '0) begin
									idx_q   <= n_act - CNT_W'(1);
									state_q <= ST_FETCH;
								end else begin
									state_q <= ST_DONE;
								end
							end
							ACT_SHIFT: begin
								acc_q <= '0;
								if (shift_go) begin
									idx_q   <= n_act - CNT_W'(2);
									state_q <= ST_FETCH;
								end else begin
									state_q <= ST_DONE;
								end
							end
							ACT_SCALE: begin
								acc_q   <= FX_ONE;
								idx_q   <= '0;
								state_q <= (n_act != '0) ? ST_ISSUE : ST_DONE;
							end
							default: begin
								acc_q   <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_FETCH: begin
					// Evaluate seeds the accumulator with the top coefficient
					if (act_q == ACT_EVAL) begin
						acc_q <= rd_data;
						if (idx_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							idx_q   <= idx_q - CNT_W'(1);
							state_q <= ST_ISSUE;
						end
					end else begin
						opa_q   <= rd_data;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mac_rsp.valid) begin
						flag_q <= flag_q | mac_rsp.sat;
						case (act_q)
							ACT_EVAL: begin
								acc_q <= mac_rsp.value;
								if (idx_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									idx_q   <= idx_q - CNT_W'(1);
									state_q <= ST_ISSUE;
								end
							end
							ACT_SHIFT: begin
								coeff_q[idx_q[IDX_W-1:0]] <= mac_rsp.value;
								if (idx_q == k_q) begin
									if (more_k) begin
										k_q     <= k_q + CNT_W'(1);
										idx_q   <= n_q - CNT_W'(2);
										state_q <= ST_FETCH;
									end else begin
										state_q <= ST_DONE;
									end
								end else begin
									idx_q   <= idx_q - CNT_W'(1);
									state_q <= ST_FETCH;
								end
							end
							ACT_SCALE: begin
								if (!phase_q) begin
									coeff_q[idx_q[IDX_W-1:0]] <= mac_rsp.value;
									if (idx_p1 < n_q) begin
										phase_q <= 1'b1;
										state_q <= ST_ISSUE;
									end else begin
										state_q <= ST_DONE;
									end
								end else begin
									acc_q   <= mac_rsp.value;
									phase_q <= 1'b0;
									idx_q   <= idx_p1;
									state_q <= ST_ISSUE;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_DONE: begin
					// Hand the result to the output register when it is free
					if (!out_valid_q || result.ready) begin
						out_value_q <= (act_q == ACT_EVAL || act_q == ACT_READ) ? acc_q : '0;
						out_sat_q   <= flag_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item.ready          = state_q == ST_IDLE;
	assign cfg.ready           = 1'b1;
	assign result.valid        = out_valid_q;
	assign result.result_value = out_value_q;
	assign result.saturated    = out_sat_q;

	`PCE_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready, !item.ready)
	`PCE_ASSERT_NOW(a_rsp_only_in_wait, mac_rsp.valid, state_q == ST_WAIT)
	`PCE_ASSERT_NEXT(a_done_delivers, state_q == ST_DONE && !result.valid, result.valid)

endmodule

/* sv/pce_mac.sv */
// Shared two-stage fixed-point multiply-add unit: sat(floor(a*b >> F)) + c, saturated.
// Depends on pce_pkg for the request/response structs and format constants.
`timescale 1ns / 1ps

module pce_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  pce_pkg::mac_req_t req,
	output pce_pkg::mac_rsp_t rsp
);
	import pce_pkg::*;

	localparam int PROD_W = 2 * DATA_W;

	logic                     valid_s1;
	logic signed [PROD_W-1:0] prod_s1;
	fx_t                      c_s1;

	logic                     valid_s2;
	fx_t                      value_s2;
	logic                     sat_s2;

	logic signed [PROD_W-1:0] shifted;
	logic                     mul_sat;
	fx_t                      mul_val;
	logic signed [DATA_W:0]   sum;
	logic                     add_sat;
	fx_t                      add_val;

	// Stage 1: full-width signed product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			prod_s1 <= PROD_W'(req.a) * PROD_W'(req.b);
			c_s1    <= req.c;
		end
	end

	// Stage 2: floor to the fraction point, clamp, add, clamp again
	always_comb begin
		shifted = prod_s1 >>> FRACTION_BITS;
		mul_sat = (shifted[PROD_W-1:DATA_W-1] != '0) && (shifted[PROD_W-1:DATA_W-1] != '1);
		if (mul_sat) begin
			mul_val = shifted[PROD_W-1] ? fx_t'({1'b1, {(DATA_W-1){1'b0}}})
				: fx_t'({1'b0, {(DATA_W-1){1'b1}}});
		end else begin
			mul_val = shifted[DATA_W-1:0];
		end
		sum     = {mul_val[DATA_W-1], mul_val} + {c_s1[DATA_W-1], c_s1};
		add_sat = sum[DATA_W] != sum[DATA_W-1];
		if (add_sat) begin
			add_val = sum[DATA_W] ? fx_t'({1'b1, {(DATA_W-1){1'b0}}})
				: fx_t'({1'b0, {(DATA_W-1){1'b1}}});
		end else begin
			add_val = sum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			value_s2 <= add_val;
			sat_s2   <= mul_sat | add_sat;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.value = value_s2;
	assign rsp.sat   = sat_s2;

endmodule
